[src/regex_literal_escaper_macros.svh]
// assertion helpers for the regex literal escaper
`ifndef REGEX_LITERAL_ESCAPER_MACROS_SVH
`define REGEX_LITERAL_ESCAPER_MACROS_SVH

`ifndef SYNTHESIS
// implication checked on every rising clock edge outside reset
`define RLESC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rlesc check failed");
// condition that must never hold outside reset
`define RLESC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("rlesc forbidden condition");
`else
`define RLESC_ASSERT_IMPL(lbl, ante, cons)
`define RLESC_ASSERT_NEVER(lbl, cond)
`endif

`endif

[src/rlesc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rlesc_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_end;
    logic       pattern_end;
  } out_word_t;

  localparam int unsigned MaxChars = 6;

  localparam logic [7:0] PrintLow  = 8'h20;
  localparam logic [7:0] PrintHigh = 8'h7e;

  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChBar       = 8'h7c;
  localparam logic [7:0] ChLParen    = 8'h28;
  localparam logic [7:0] ChRParen    = 8'h29;
  localparam logic [7:0] ChStar      = 8'h2a;
  localparam logic [7:0] ChPlus      = 8'h2b;
  localparam logic [7:0] ChDot       = 8'h2e;
  localparam logic [7:0] ChSlash     = 8'h2f;
  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChDollar    = 8'h24;
  localparam logic [7:0] ChQuestion  = 8'h3f;
  localparam logic [7:0] ChLBracket  = 8'h5b;
  localparam logic [7:0] ChRBracket  = 8'h5d;
  localparam logic [7:0] ChCaret     = 8'h5e;
  localparam logic [7:0] ChLBrace    = 8'h7b;
  localparam logic [7:0] ChRBrace    = 8'h7d;

  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChReturn  = 8'h0d;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChLowerN  = 8'h6e;
  localparam logic [7:0] ChLowerR  = 8'h72;
  localparam logic [7:0] ChLowerT  = 8'h74;
  localparam logic [7:0] ChLowerX  = 8'h78;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChLowerA  = 8'h61;

endpackage
`default_nettype wire

[src/regex_literal_escaper.sv]
`timescale 1ns / 1ps
`default_nettype none
// Escapes a literal pattern one byte at a time into regex-safe text, one character per
// output word. An input word expands to 1 to 6 characters: one for a plain printable
// byte, two for a metacharacter or \n \r \t, four for a \xhh escape, plus one for each
// anchor when anchor_mode is set and the byte is first or last. The block sends one
// character per cycle while the receiver is ready; the next item is taken in the cycle the
// previous one's last character moves to the output register. An accepted input word is
// expanded into the holding stage, and its characters move from there to the output
// register. anchor_mode is written through the cfg channel, which is always ready, and is
// sampled when an input word is accepted.
`include "regex_literal_escaper_macros.svh"
module regex_literal_escaper (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rlesc_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rlesc_pkg::out_word_t    out_data
);

  logic anchor_mode;

  // expansion of the incoming byte
  logic [7:0] x_chars [rlesc_pkg::MaxChars];
  logic [2:0] x_cnt;

  // holding stage: one expanded item, walked by idx
  logic       hold_valid;
  logic [7:0] hold_chars [rlesc_pkg::MaxChars];
  logic [2:0] hold_cnt;
  logic       hold_last;
  logic [2:0] idx;

  logic load_out;
  logic hold_done;
  logic in_fire;

  function automatic logic is_meta(input logic [7:0] c);
    logic r;
    r = 1'b0;
    case (c) inside
      rlesc_pkg::ChBackslash, rlesc_pkg::ChBar, rlesc_pkg::ChLParen, rlesc_pkg::ChRParen,
      rlesc_pkg::ChStar, rlesc_pkg::ChPlus, rlesc_pkg::ChDot, rlesc_pkg::ChSlash,
      rlesc_pkg::ChHash, rlesc_pkg::ChDollar, rlesc_pkg::ChQuestion,
      rlesc_pkg::ChLBracket, rlesc_pkg::ChRBracket, rlesc_pkg::ChCaret,
      rlesc_pkg::ChLBrace, rlesc_pkg::ChRBrace: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = rlesc_pkg::ChZero + {4'd0, v};
    end else begin
      r = rlesc_pkg::ChLowerA + {4'd0, v} - 8'd10;
    end
    return r;
  endfunction

  always_comb begin
    logic [2:0] pos;
    logic [7:0] b;
    pos = 3'd0;
    b = in_data.in_byte;
    for (int i = 0; i < rlesc_pkg::MaxChars; i++) begin
      x_chars[i] = 8'd0;
    end
    if (anchor_mode && in_data.first_byte) begin
      x_chars[pos] = rlesc_pkg::ChCaret;
      pos = pos + 3'd1;
    end
    if (b >= rlesc_pkg::PrintLow && b <= rlesc_pkg::PrintHigh) begin
      if (is_meta(b)) begin
        x_chars[pos] = rlesc_pkg::ChBackslash;
        pos = pos + 3'd1;
      end
      x_chars[pos] = b;
      pos = pos + 3'd1;
    end else if (b == rlesc_pkg::ChNewline || b == rlesc_pkg::ChReturn ||
                 b == rlesc_pkg::ChTab) begin
      x_chars[pos] = rlesc_pkg::ChBackslash;
      pos = pos + 3'd1;
      if (b == rlesc_pkg::ChNewline) begin
        x_chars[pos] = rlesc_pkg::ChLowerN;
      end else if (b == rlesc_pkg::ChReturn) begin
        x_chars[pos] = rlesc_pkg::ChLowerR;
      end else begin
        x_chars[pos] = rlesc_pkg::ChLowerT;
      end
      pos = pos + 3'd1;
    end else begin
      x_chars[pos] = rlesc_pkg::ChBackslash;
      x_chars[pos + 3'd1] = rlesc_pkg::ChLowerX;
      x_chars[pos + 3'd2] = hex_digit(b[7:4]);
      x_chars[pos + 3'd3] = hex_digit(b[3:0]);
      pos = pos + 3'd4;
    end
    if (anchor_mode && in_data.last_byte) begin
      x_chars[pos] = rlesc_pkg::ChDollar;
      pos = pos + 3'd1;
    end
    x_cnt = pos;
  end

  assign cfg_ready = 1'b1;
  assign load_out  = hold_valid && (!out_valid || out_ready);
  assign hold_done = load_out && (idx == hold_cnt - 3'd1);
  assign in_ready  = !hold_valid || hold_done;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_mode <= 1'b0;
    end else if (cfg_valid) begin
      anchor_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      idx        <= 3'd0;
    end else if (in_fire) begin
      hold_valid <= 1'b1;
      idx        <= 3'd0;
    end else if (hold_done) begin
      hold_valid <= 1'b0;
      idx        <= 3'd0;
    end else if (load_out) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_chars <= x_chars;
      hold_cnt   <= x_cnt;
      hold_last  <= in_data.last_byte;
    end
  end

  // output register, one character per word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.out_char    <= hold_chars[idx];
      out_data.run_end     <= (idx == hold_cnt - 3'd1);
      out_data.pattern_end <= (idx == hold_cnt - 3'd1) && hold_last;
    end
  end

  `RLESC_ASSERT_IMPL(a_idx_in_range, hold_valid, idx < hold_cnt)
  `RLESC_ASSERT_IMPL(a_cnt_range, hold_valid, hold_cnt >= 3'd1 && hold_cnt <= 3'd6)
  `RLESC_ASSERT_IMPL(a_take_only_when_done, in_fire && hold_valid, hold_done)
  `RLESC_ASSERT_NEVER(a_pend_without_rend,
      out_valid && out_data.pattern_end && !out_data.run_end)
  `RLESC_ASSERT_IMPL(a_done_sends_run_end, hold_done, ##1 (out_valid && out_data.run_end))

endmodule
`default_nettype wire

[sim/rlesc_checker.sv]
`timescale 1ns / 1ps
module rlesc_checker (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  input  wire logic                 cfg_ready,
  input  wire logic                 cfg_data,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire rlesc_pkg::in_word_t  in_data,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire rlesc_pkg::out_word_t out_data,
  output int                        errors,
  output int                        pending,
  output int                        chars_checked
);

  logic                 anchored = 1'b0;
  rlesc_pkg::out_word_t escaped_chars[$];

  function automatic logic is_metachar(logic [7:0] c);
    case (c) inside
      rlesc_pkg::ChBackslash, rlesc_pkg::ChBar, rlesc_pkg::ChLParen, rlesc_pkg::ChRParen,
      rlesc_pkg::ChStar, rlesc_pkg::ChPlus, rlesc_pkg::ChDot, rlesc_pkg::ChSlash,
      rlesc_pkg::ChHash, rlesc_pkg::ChDollar, rlesc_pkg::ChQuestion,
      rlesc_pkg::ChLBracket, rlesc_pkg::ChRBracket, rlesc_pkg::ChCaret,
      rlesc_pkg::ChLBrace, rlesc_pkg::ChRBrace: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return rlesc_pkg::ChZero + {4'b0, v};
    return rlesc_pkg::ChLowerA + {4'b0, v} - 8'd10;
  endfunction

  // queues every character one accepted byte turns into
  function automatic void escape_byte(rlesc_pkg::in_word_t w);
    logic [7:0]           chars [rlesc_pkg::MaxChars];
    int                   n;
    rlesc_pkg::out_word_t c;
    n = 0;
    if (anchored && w.first_byte) begin
      chars[n] = rlesc_pkg::ChCaret;
      n++;
    end
    if (w.in_byte >= rlesc_pkg::PrintLow && w.in_byte <= rlesc_pkg::PrintHigh) begin
      if (is_metachar(w.in_byte)) begin
        chars[n] = rlesc_pkg::ChBackslash;
        n++;
      end
      chars[n] = w.in_byte;
      n++;
    end else begin
      chars[n] = rlesc_pkg::ChBackslash;
      n++;
      case (w.in_byte)
        rlesc_pkg::ChNewline: begin
          chars[n] = rlesc_pkg::ChLowerN;
          n++;
        end
        rlesc_pkg::ChReturn: begin
          chars[n] = rlesc_pkg::ChLowerR;
          n++;
        end
        rlesc_pkg::ChTab: begin
          chars[n] = rlesc_pkg::ChLowerT;
          n++;
        end
        default: begin
          chars[n] = rlesc_pkg::ChLowerX;
          chars[n + 1] = hex_char(w.in_byte[7:4]);
          chars[n + 2] = hex_char(w.in_byte[3:0]);
          n += 3;
        end
      endcase
    end
    if (anchored && w.last_byte) begin
      chars[n] = rlesc_pkg::ChDollar;
      n++;
    end
    for (int i = 0; i < n; i++) begin
      c.out_char    = chars[i];
      c.run_end     = (i == n - 1);
      c.pattern_end = (i == n - 1) && w.last_byte;
      escaped_chars.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    rlesc_pkg::out_word_t want;
    if (rst) begin
      anchored = 1'b0;
      escaped_chars.delete();
      errors = 0;
      chars_checked = 0;
    end else begin
      // the block expands a word with the mode held before this edge
      if (in_valid && in_ready) escape_byte(in_data);
      if (cfg_valid && cfg_ready) anchored = cfg_data;
      if (out_valid && out_ready) begin
        if (escaped_chars.size() == 0) begin
          $display("%0t: unexpected word, expected none, got char %h run_end %b %s %b",
                   $time, out_data.out_char, out_data.run_end, "pattern_end",
                   out_data.pattern_end);
          errors++;
        end else begin
          want = escaped_chars.pop_front();
          chars_checked++;
          if (out_data.out_char !== want.out_char || out_data.run_end !== want.run_end ||
              out_data.pattern_end !== want.pattern_end) begin
            $display("%0t: mismatch, expected char %h run_end %b pattern_end %b,",
                     $time, want.out_char, want.run_end, want.pattern_end);
            $display("%0t:   got char %h run_end %b pattern_end %b",
                     $time, out_data.out_char, out_data.run_end, out_data.pattern_end);
            errors++;
          end
        end
      end
    end
    pending = escaped_chars.size();
  end

endmodule

[sim/tb_regex_literal_escaper.sv]
`timescale 1ns / 1ps
module tb_regex_literal_escaper;

  typedef enum logic [1:0] {
    ReadyAlways, ReadyRandom, ReadyPeriodic, ReadyHeavy
  } ready_mode_t;

  localparam int QuietLimit  = 2000;
  localparam int DrainCycles = 8;

  localparam logic [15:0][7:0] MetaChars = {
    rlesc_pkg::ChBackslash, rlesc_pkg::ChBar, rlesc_pkg::ChLParen, rlesc_pkg::ChRParen,
    rlesc_pkg::ChStar, rlesc_pkg::ChPlus, rlesc_pkg::ChDot, rlesc_pkg::ChSlash,
    rlesc_pkg::ChHash, rlesc_pkg::ChDollar, rlesc_pkg::ChQuestion, rlesc_pkg::ChLBracket,
    rlesc_pkg::ChRBracket, rlesc_pkg::ChCaret, rlesc_pkg::ChLBrace, rlesc_pkg::ChRBrace
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_data = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  rlesc_pkg::in_word_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rlesc_pkg::out_word_t out_data;

  int errors;
  int pending;
  int chars_checked;

  ready_mode_t ready_mode = ReadyAlways;
  int unsigned stall_phase = 0;
  logic        gaps_on = 1'b1;
  int          burst_left = 0;
  int          bytes_sent = 0;

  regex_literal_escaper dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  rlesc_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .errors        (errors),
    .pending       (pending),
    .chars_checked (chars_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    case (ready_mode)
      ReadyAlways:   out_ready <= 1'b1;
      ReadyRandom:   out_ready <= ($urandom_range(0, 3) != 0);
      ReadyPeriodic: out_ready <= ((stall_phase % 7) < 4);
      default:       out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(rlesc_pkg::PrintLow, rlesc_pkg::PrintHigh));
      4, 5:       return MetaChars[$urandom_range(0, 15)];
      6: begin
        case ($urandom_range(0, 2))
          0:       return rlesc_pkg::ChNewline;
          1:       return rlesc_pkg::ChReturn;
          default: return rlesc_pkg::ChTab;
        endcase
      end
      7:       return 8'($urandom_range(0, 31));
      8:       return 8'($urandom_range(127, 255));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    rlesc_pkg::in_word_t w;
    w.in_byte    = b;
    w.first_byte = first;
    w.last_byte  = last;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) burst_left--;
    bytes_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_anchor(input logic mode);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed patterns, some with scrambled first/last flags
  task automatic send_patterns(input int count);
    int   sent;
    int   len;
    logic noisy;
    sent = 0;
    while (sent < count) begin
      len   = $urandom_range(1, 8);
      noisy = ($urandom_range(0, 6) == 0);
      for (int i = 0; i < len; i++) begin
        if (noisy) send_byte(pick_byte(), 1'($urandom), 1'($urandom));
        else send_byte(pick_byte(), i == 0, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, QuietLimit);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // plain mode: printable bounds and every escape class
    ready_mode = ReadyRandom;
    write_anchor(1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h1f, 1'b0, 1'b0);
    send_byte(rlesc_pkg::PrintLow, 1'b0, 1'b0);
    send_byte(rlesc_pkg::PrintHigh, 1'b0, 1'b0);
    send_byte(8'h7f, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(rlesc_pkg::ChNewline, 1'b0, 1'b0);
    send_byte(rlesc_pkg::ChReturn, 1'b0, 1'b0);
    send_byte(rlesc_pkg::ChTab, 1'b0, 1'b0);
    send_byte(rlesc_pkg::ChStar, 1'b0, 1'b0);
    send_byte(8'h41, 1'b0, 1'b1);
    wait_idle();

    // anchored mode: one-byte patterns, widest expansion, flags out of order
    write_anchor(1'b1);
    send_byte(rlesc_pkg::ChCaret, 1'b1, 1'b1);
    send_byte(8'ha5, 1'b1, 1'b1);
    send_byte(rlesc_pkg::ChDollar, 1'b1, 1'b0);
    send_byte(rlesc_pkg::ChBackslash, 1'b0, 1'b0);
    send_byte(rlesc_pkg::ChLBrace, 1'b0, 1'b0);
    send_byte(rlesc_pkg::ChRBrace, 1'b0, 1'b1);
    send_byte(8'h80, 1'b0, 1'b1);
    send_byte(8'h7a, 1'b0, 1'b1);
    send_byte(rlesc_pkg::ChNewline, 1'b1, 1'b0);
    send_byte(rlesc_pkg::PrintLow, 1'b0, 1'b0);
    send_byte(8'hff, 1'b1, 1'b1);
    wait_idle();

    write_anchor(1'b0);
    send_patterns(85);
    wait_idle();

    // back-to-back with no stalls on either side
    gaps_on    = 1'b0;
    ready_mode = ReadyAlways;
    write_anchor(1'b1);
    send_patterns(85);
    wait_idle();

    gaps_on    = 1'b1;
    ready_mode = ReadyPeriodic;
    write_anchor(1'b0);
    send_patterns(42);
    wait_idle();
    send_patterns(43);
    wait_idle();

    ready_mode = ReadyHeavy;
    write_anchor(1'b1);
    send_patterns(85);
    wait_idle();

    $display("covered %0d input bytes in both anchor modes, %0d escaped characters checked",
             bytes_sent, chars_checked);
    $display("sender bursts and gaps against free, random, periodic and heavy receiver stalls");
    if (errors == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
